/* rtl/edw_pkg.sv */
`timescale 1ns / 1ps
package edw_pkg;

  localparam int FUNC_W   = 2;
  localparam int WHOLE_W  = 16;
  localparam int MICRO_W  = 21;
  localparam int STEP_W   = 16;
  localparam int DET_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_ACCEPT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_CW_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CCW_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DETENTS  = 2'd2;

  localparam logic signed [STEP_W-1:0] CW_STEP_RST  = -16'sd1;
  localparam logic signed [STEP_W-1:0] CCW_STEP_RST = 16'sd1;
  localparam logic [DET_W-1:0]         DETENTS_RST  = 9'd20;

  localparam int MICRO_PER_DEG = 1000000;
  localparam int FULL_TURN     = 360;

  localparam int DIV_W     = 17;
  localparam int SPAN_W    = 9;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic signed [WHOLE_W-1:0] rem_degrees;
    logic signed [MICRO_W-1:0] rem_micro;
    logic signed [MICRO_W-1:0] pending_count;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

endpackage

/* rtl/edw_if.sv */
`timescale 1ns / 1ps
interface edw_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [edw_pkg::FUNC_W-1:0]           func;
  logic                                 enc_sel;
  logic [2:0]                           layer;
  logic signed [edw_pkg::WHOLE_W-1:0]   whole_degrees;
  logic signed [edw_pkg::MICRO_W-1:0]   micro_degrees;

  modport source(output valid, func, enc_sel, layer, whole_degrees, micro_degrees,
                 input ready);
  modport sink(input valid, func, enc_sel, layer, whole_degrees, micro_degrees,
               output ready);
endinterface

interface edw_out_if;
  logic                                valid;
  logic                                ready;
  logic                                report_valid;
  logic signed [edw_pkg::STEP_W-1:0]   wheel_amount;

  modport source(output valid, report_valid, wheel_amount, input ready);
  modport sink(input valid, report_valid, wheel_amount, output ready);
endinterface

interface edw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [edw_pkg::CFG_IDX_W-1:0]      index;
  logic [edw_pkg::CFG_DATA_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/edw_ram.sv */
`timescale 1ns / 1ps
module edw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/edw_div.sv */
`timescale 1ns / 1ps
module edw_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [edw_pkg::DIV_W-1:0]     dividend,
  input  logic [edw_pkg::SPAN_W-1:0]    divisor,
  output logic                          done,
  output logic [edw_pkg::DIV_W-1:0]     quotient,
  output logic [edw_pkg::SPAN_W-1:0]    remainder
);

  logic                              busy_r;
  logic                              done_r;
  logic [edw_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [edw_pkg::DIV_W-1:0]         dvd_r;
  logic [edw_pkg::SPAN_W-1:0]        part_r;
  logic [edw_pkg::SPAN_W-1:0]        dsr_r;
  logic [edw_pkg::SPAN_W:0]          trial;
  logic [edw_pkg::SPAN_W:0]          diff;
  logic                              qbit;

  assign trial = {part_r, dvd_r[edw_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == edw_pkg::DIV_CNT_W'(edw_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      part_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[edw_pkg::DIV_W-2:0], qbit};
      part_r <= qbit ? diff[edw_pkg::SPAN_W-1:0] : trial[edw_pkg::SPAN_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = part_r;

endmodule

/* rtl/encoder_detent_to_wheel_core.sv */
`timescale 1ns / 1ps
// Detent accumulator: one transaction in gives exactly one transaction out. An angle
// transaction with nonzero whole degrees runs through the serial restoring divider
// (two passes: 360 by detents, then degrees by span); a direct-count angle or a
// process transaction goes through the slot memory read-modify-write. Slot
// state sits in one synchronous RAM; after reset a clearing pass zeroes each of its
// SENSOR_COUNT*LAYER_COUNT slots, with input held off. A finished result waits in an
// output register while the next transaction is taken.
module encoder_detent_to_wheel_core #(
  parameter int SENSOR_COUNT = 2,
  parameter int LAYER_COUNT  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  edw_cfg_if.sink      cfg_ch,
  edw_in_if.sink       in_ch,
  edw_out_if.source    out_ch
);

  localparam int SLOTS  = SENSOR_COUNT * LAYER_COUNT;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_SPAN  = 7'b0001000,
    ST_QUOT  = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]                    clr_r;
  logic signed [edw_pkg::STEP_W-1:0]    cw_r;
  logic signed [edw_pkg::STEP_W-1:0]    ccw_r;
  logic [edw_pkg::DET_W-1:0]            det_r;
  logic [edw_pkg::SPAN_W-1:0]           det_c;

  logic [edw_pkg::FUNC_W-1:0]           func_r;
  logic [SLOT_W-1:0]                    slot_r;
  logic signed [edw_pkg::WHOLE_W-1:0]   whole_r;
  logic signed [edw_pkg::MICRO_W-1:0]   micro_r;
  logic [edw_pkg::DIV_W-1:0]            dabs_r;
  logic                                 neg_r;
  logic signed [edw_pkg::MICRO_W-1:0]   m_r;
  logic [edw_pkg::STEP_W-1:0]           step_r;
  logic [edw_pkg::STEP_W-1:0]           mag_r;
  logic                                 res_valid_r;
  logic [edw_pkg::STEP_W-1:0]           res_amt_r;
  logic                                 out_valid_r;
  logic                                 out_rv_r;
  logic [edw_pkg::STEP_W-1:0]           out_amt_r;

  logic                                 in_acc;
  logic                                 in_range;
  logic [SLOT_W-1:0]                    slot_in;
  logic                                 out_free;

  logic                                 ram_we;
  logic [SLOT_W-1:0]                    ram_waddr;
  logic [edw_pkg::SLOT_BITS-1:0]        ram_wdata;
  logic                                 ram_re;
  logic [edw_pkg::SLOT_BITS-1:0]        ram_rdata;
  edw_pkg::slot_t                       rd_slot;
  edw_pkg::slot_t                       keep_slot;
  edw_pkg::slot_t                       new_slot;

  logic signed [17:0]                   d_sum;
  logic signed [21:0]                   m_sum;
  logic signed [17:0]                   d_adj;
  logic signed [21:0]                   m_adj;
  logic [17:0]                          d_abs;
  logic [edw_pkg::MICRO_W-1:0]          t_abs;
  logic                                 t_neg;
  logic [31:0]                          prod;
  logic [edw_pkg::MICRO_W-1:0]          q_ext;
  logic [edw_pkg::WHOLE_W-1:0]          r_ext;

  logic                                 div_start;
  logic [edw_pkg::DIV_W-1:0]            div_dvd;
  logic [edw_pkg::SPAN_W-1:0]           div_dsr;
  logic                                 div_done;
  logic [edw_pkg::DIV_W-1:0]            div_quo;
  logic [edw_pkg::SPAN_W-1:0]           div_rem;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign in_range     = (32'(in_ch.enc_sel) < SENSOR_COUNT) &&
                        (32'(in_ch.layer) < LAYER_COUNT);
  assign slot_in      = SLOT_W'(32'(in_ch.enc_sel) * LAYER_COUNT + 32'(in_ch.layer));
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.report_valid = out_rv_r;
  assign out_ch.wheel_amount = out_amt_r;

  assign det_c = (det_r == '0) ? edw_pkg::SPAN_W'(1) :
                 (det_r > edw_pkg::DET_W'(edw_pkg::FULL_TURN)) ?
                 edw_pkg::SPAN_W'(edw_pkg::FULL_TURN) : det_r;

  assign rd_slot = edw_pkg::slot_t'(ram_rdata);

  // carry whole degrees out of the micro-degree sum
  assign d_sum = 18'($signed(rd_slot.rem_degrees)) + 18'($signed(whole_r));
  assign m_sum = 22'($signed(rd_slot.rem_micro)) + 22'($signed(micro_r));
  always_comb begin
    d_adj = d_sum;
    m_adj = m_sum;
    if (m_sum >= 22'(2 * edw_pkg::MICRO_PER_DEG)) begin
      d_adj = d_sum + 18'sd2;
      m_adj = m_sum - 22'(2 * edw_pkg::MICRO_PER_DEG);
    end else if (m_sum >= 22'(edw_pkg::MICRO_PER_DEG)) begin
      d_adj = d_sum + 18'sd1;
      m_adj = m_sum - 22'(edw_pkg::MICRO_PER_DEG);
    end else if (m_sum <= -22'(2 * edw_pkg::MICRO_PER_DEG)) begin
      d_adj = d_sum - 18'sd2;
      m_adj = m_sum + 22'(2 * edw_pkg::MICRO_PER_DEG);
    end else if (m_sum <= -22'(edw_pkg::MICRO_PER_DEG)) begin
      d_adj = d_sum - 18'sd1;
      m_adj = m_sum + 22'(edw_pkg::MICRO_PER_DEG);
    end
  end
  assign d_abs = d_adj[17] ? 18'(-d_adj) : 18'(d_adj);

  assign t_neg = rd_slot.pending_count[edw_pkg::MICRO_W-1];
  assign t_abs = t_neg ? -rd_slot.pending_count : rd_slot.pending_count;

  assign prod = step_r * mag_r;

  assign q_ext = edw_pkg::MICRO_W'(div_quo);
  assign r_ext = edw_pkg::WHOLE_W'(div_rem);

  always_comb begin
    keep_slot               = rd_slot;
    keep_slot.pending_count = '0;
    new_slot.rem_degrees    = neg_r ? -r_ext : r_ext;
    new_slot.rem_micro      = m_r;
    new_slot.pending_count  = neg_r ? -q_ext : q_ext;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    div_dvd   = edw_pkg::DIV_W'(edw_pkg::FULL_TURN);
    div_dsr   = det_c;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      ST_IDLE: begin
        ram_re = in_acc && in_range;
      end
      ST_READ: begin
        if (func_r == edw_pkg::FUNC_ACCEPT) begin
          if (whole_r == '0) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_slot.rem_degrees, rd_slot.rem_micro, micro_r};
          end else begin
            div_start = 1'b1;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = keep_slot;
        end
      end
      ST_SPAN: begin
        div_start = div_done;
        div_dvd   = dabs_r;
        div_dsr   = div_quo[edw_pkg::SPAN_W-1:0];
      end
      ST_QUOT: begin
        ram_we    = div_done;
        ram_wdata = new_slot;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == SLOT_W'(SLOTS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = in_range ? ST_READ : ST_FIN;
      ST_READ: begin
        if (func_r == edw_pkg::FUNC_ACCEPT && whole_r != '0) begin
          state_nxt = ST_SPAN;
        end else if (func_r == edw_pkg::FUNC_TRIGGER) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SPAN:  if (div_done) state_nxt = ST_QUOT;
      ST_QUOT:  if (div_done) state_nxt = ST_FIN;
      ST_MUL:   state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cw_r        <= edw_pkg::CW_STEP_RST;
      ccw_r       <= edw_pkg::CCW_STEP_RST;
      det_r       <= edw_pkg::DETENTS_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          edw_pkg::CFG_CW_STEP:  cw_r  <= cfg_ch.data;
          edw_pkg::CFG_CCW_STEP: ccw_r <= cfg_ch.data;
          edw_pkg::CFG_DETENTS:  det_r <= cfg_ch.data[edw_pkg::DET_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r      <= in_ch.func;
      slot_r      <= slot_in;
      whole_r     <= in_ch.whole_degrees;
      micro_r     <= in_ch.micro_degrees;
      res_valid_r <= 1'b0;
      res_amt_r   <= '0;
    end
    if (state_r == ST_READ) begin
      dabs_r <= d_abs[edw_pkg::DIV_W-1:0];
      neg_r  <= d_adj[17];
      m_r    <= m_adj[edw_pkg::MICRO_W-1:0];
      step_r <= t_neg ? ccw_r : cw_r;
      mag_r  <= t_abs[edw_pkg::STEP_W-1:0];
      if (func_r == edw_pkg::FUNC_TRIGGER) begin
        res_valid_r <= (rd_slot.pending_count != '0);
      end
    end
    if (state_r == ST_MUL) begin
      res_amt_r <= prod[edw_pkg::STEP_W-1:0];
    end
    if (state_r == ST_FIN && out_free) begin
      out_rv_r  <= res_valid_r;
      out_amt_r <= res_amt_r;
    end
  end

  edw_ram #(
    .WIDTH (edw_pkg::SLOT_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_in),
    .rdata (ram_rdata)
  );

  edw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_SPAN || state_r == ST_QUOT))
    else $error("divider finished outside a divide state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !(state_r == ST_IDLE || state_r == ST_FIN))
    else $error("slot write while no transaction in flight");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (ram_we && ram_wdata == '0))
    else $error("clearing pass not writing zero");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted transaction dropped");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> out_valid_r)
    else $error("result not presented");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int SENSORS     = 2;
  localparam int LAYERS      = 8;
  localparam int SLOTS       = SENSORS * LAYERS;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 175;
  localparam int HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 60;

  localparam logic [edw_pkg::FUNC_W-1:0]    FUNC_OTHER = 2'd2;
  localparam logic [edw_pkg::FUNC_W-1:0]    FUNC_SPARE = 2'd3;
  localparam logic [edw_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [edw_pkg::FUNC_W-1:0]         func;
    logic                               sensor;
    logic [2:0]                         layer;
    logic signed [edw_pkg::WHOLE_W-1:0] whole;
    logic signed [edw_pkg::MICRO_W-1:0] micro;
  } encoder_item_t;

  typedef struct packed {
    logic                              report_valid;
    logic signed [edw_pkg::STEP_W-1:0] wheel_amount;
  } wheel_report_t;

  class wheel_report_tracker;
    logic signed [edw_pkg::WHOLE_W-1:0] rem_deg [SLOTS];
    logic signed [edw_pkg::MICRO_W-1:0] rem_udeg [SLOTS];
    logic signed [edw_pkg::MICRO_W-1:0] held_count [SLOTS];
    logic signed [edw_pkg::STEP_W-1:0]  cw_step;
    logic signed [edw_pkg::STEP_W-1:0]  ccw_step;
    logic [edw_pkg::DET_W-1:0]          detents;
    wheel_report_t                      awaited_reports [$];
    int                                 mismatches;

    function new();
      foreach (rem_deg[i]) begin
        rem_deg[i]    = '0;
        rem_udeg[i]   = '0;
        held_count[i] = '0;
      end
      cw_step    = edw_pkg::CW_STEP_RST;
      ccw_step   = edw_pkg::CCW_STEP_RST;
      detents    = edw_pkg::DETENTS_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [edw_pkg::CFG_IDX_W-1:0] idx,
                          logic [edw_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        edw_pkg::CFG_CW_STEP:  cw_step  = data;
        edw_pkg::CFG_CCW_STEP: ccw_step = data;
        edw_pkg::CFG_DETENTS:  detents  = data[edw_pkg::DET_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(encoder_item_t it);
      int            slot;
      int            det;
      longint        deg;
      longint        udeg;
      longint        span;
      longint        cnt;
      longint        held;
      longint        step;
      longint        amount;
      wheel_report_t r;
      slot = int'(it.sensor) * LAYERS + int'(it.layer);
      r = '0;
      case (it.func)
        edw_pkg::FUNC_ACCEPT: begin
          if (it.whole == 0) begin
            held_count[slot] = it.micro;
          end else begin
            deg  = longint'(rem_deg[slot]) + longint'($signed(it.whole));
            udeg = longint'(rem_udeg[slot]) + longint'($signed(it.micro));
            if (udeg >= edw_pkg::MICRO_PER_DEG || udeg <= -edw_pkg::MICRO_PER_DEG) begin
              deg  = deg + udeg / edw_pkg::MICRO_PER_DEG;
              udeg = udeg % edw_pkg::MICRO_PER_DEG;
            end
            det = int'(detents);
            if (det == 0) det = 1;
            if (det > edw_pkg::FULL_TURN) det = edw_pkg::FULL_TURN;
            span = longint'(edw_pkg::FULL_TURN / det);
            cnt  = deg / span;
            deg  = deg % span;
            rem_deg[slot]    = deg[edw_pkg::WHOLE_W-1:0];
            rem_udeg[slot]   = udeg[edw_pkg::MICRO_W-1:0];
            held_count[slot] = cnt[edw_pkg::MICRO_W-1:0];
          end
        end
        edw_pkg::FUNC_TRIGGER: begin
          held = longint'(held_count[slot]);
          held_count[slot] = '0;
          if (held != 0) begin
            step   = (held > 0) ? longint'(cw_step) : longint'(ccw_step);
            amount = step * ((held < 0) ? -held : held);
            r.report_valid = 1'b1;
            r.wheel_amount = amount[edw_pkg::STEP_W-1:0];
          end
        end
        default: held_count[slot] = '0;
      endcase
      awaited_reports.push_back(r);
    endfunction

    function void check_report(logic rv, logic signed [edw_pkg::STEP_W-1:0] amount);
      wheel_report_t e;
      if (awaited_reports.size() == 0) begin
        $display("%0t: report expected none actual valid=%0b amount=%0d",
                 $time, rv, amount);
        mismatches++;
        return;
      end
      e = awaited_reports.pop_front();
      if (rv !== e.report_valid) begin
        $display("%0t: report_valid expected %0b actual %0b", $time, e.report_valid, rv);
        mismatches++;
      end
      if (amount !== e.wheel_amount) begin
        $display("%0t: wheel_amount expected %0d actual %0d", $time, e.wheel_amount, amount);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_req;
  bit   hold_taken;
  int   hold_left;

  wheel_report_tracker board;

  edw_in_if  in_if();
  edw_out_if out_if();
  edw_cfg_if cfg_if();

  encoder_detent_to_wheel_core #(
    .SENSOR_COUNT(SENSORS),
    .LAYER_COUNT (LAYERS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_if),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("encoder_detent_to_wheel_core: mismatch");
    $finish;
  end

  initial begin
    hold_left  = 0;
    hold_taken = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        board.check_report(out_if.report_valid, out_if.wheel_amount);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_item(encoder_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.func          <= it.func;
    in_if.enc_sel       <= it.sensor;
    in_if.layer         <= it.layer;
    in_if.whole_degrees <= it.whole;
    in_if.micro_degrees <= it.micro;
    do @(posedge clk); while (!in_if.ready);
    board.take_item(it);
  endtask

  task automatic send(logic [edw_pkg::FUNC_W-1:0] f, logic s, logic [2:0] l,
                      logic signed [edw_pkg::WHOLE_W-1:0] w,
                      logic signed [edw_pkg::MICRO_W-1:0] m);
    encoder_item_t it;
    it = '{func: f, sensor: s, layer: l, whole: w, micro: m};
    send_item(it);
  endtask

  task automatic write_reg(logic [edw_pkg::CFG_IDX_W-1:0] idx,
                           logic [edw_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_reg(idx, data);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.awaited_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [edw_pkg::MICRO_W-1:0] pick_micro();
    int m;
    if ($urandom_range(1)) begin
      m = int'($urandom_range(1999998)) - 999999;
      return m[edw_pkg::MICRO_W-1:0];
    end
    return edw_pkg::MICRO_W'($urandom());
  endfunction

  function automatic logic signed [edw_pkg::WHOLE_W-1:0] pick_whole();
    int w;
    int r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 40) return edw_pkg::WHOLE_W'($urandom());
    w = int'($urandom_range(1440)) - 720;
    if (w == 0) w = 1;
    return w[edw_pkg::WHOLE_W-1:0];
  endfunction

  task automatic run_phase(int n);
    int            sent;
    int            k;
    logic          s;
    logic [2:0]    l;
    encoder_item_t it;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 70) begin
        s = 1'($urandom_range(1));
        l = 3'($urandom_range(7));
        k = $urandom_range(1, 3);
        repeat (k) begin
          send(edw_pkg::FUNC_ACCEPT, s, l, pick_whole(), pick_micro());
          sent++;
        end
        if ($urandom_range(9) == 0)
          send($urandom_range(1) ? FUNC_OTHER : FUNC_SPARE, s, l, pick_whole(), pick_micro());
        else
          send(edw_pkg::FUNC_TRIGGER, s, l, pick_whole(), pick_micro());
        sent++;
      end else begin
        it.func   = edw_pkg::FUNC_W'($urandom_range(3));
        it.sensor = 1'($urandom_range(1));
        it.layer  = 3'($urandom_range(7));
        it.whole  = edw_pkg::WHOLE_W'($urandom());
        it.micro  = edw_pkg::MICRO_W'($urandom());
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 1'b0;
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.func          <= edw_pkg::FUNC_ACCEPT;
    in_if.enc_sel       <= 1'b0;
    in_if.layer         <= '0;
    in_if.whole_degrees <= '0;
    in_if.micro_degrees <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= edw_pkg::CFG_CW_STEP;
    cfg_if.data         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // direct counts, extremes of both fields, carries and clearing modes
    send(edw_pkg::FUNC_ACCEPT,  1'b0, 3'd0, 16'sd0, 21'sd5);
    send(edw_pkg::FUNC_TRIGGER, 1'b0, 3'd0, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd7, 16'sd0, -21'sd1048576);
    send(edw_pkg::FUNC_TRIGGER, 1'b1, 3'd7, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd0, 16'sd0, 21'sd1048575);
    send(FUNC_SPARE,            1'b1, 3'd0, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_TRIGGER, 1'b1, 3'd0, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_TRIGGER, 1'b0, 3'd5, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b0, 3'd1, 16'sd32767, 21'sd999999);
    send(edw_pkg::FUNC_TRIGGER, 1'b0, 3'd1, -16'sd1, -21'sd1);
    send(edw_pkg::FUNC_ACCEPT,  1'b0, 3'd2, -16'sd32768, -21'sd999999);
    send(edw_pkg::FUNC_TRIGGER, 1'b0, 3'd2, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b0, 3'd3, 16'sd17, 21'sd999999);
    send(edw_pkg::FUNC_ACCEPT,  1'b0, 3'd3, 16'sd1, 21'sd1);
    send(edw_pkg::FUNC_TRIGGER, 1'b0, 3'd3, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd1, -16'sd1, -21'sd1048576);
    send(edw_pkg::FUNC_TRIGGER, 1'b1, 3'd1, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd2, 16'sd1, 21'sd0);
    send(FUNC_OTHER,            1'b1, 3'd2, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd3, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_TRIGGER, 1'b1, 3'd3, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd4, 16'sd5, 21'sd1048575);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd4, 16'sd5, 21'sd1048575);
    send(edw_pkg::FUNC_TRIGGER, 1'b1, 3'd4, 16'sd0, 21'sd0);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd5, -16'sd5, -21'sd1048576);
    send(edw_pkg::FUNC_ACCEPT,  1'b1, 3'd5, -16'sd5, -21'sd1048576);
    send(edw_pkg::FUNC_TRIGGER, 1'b1, 3'd5, 16'sd0, 21'sd0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(edw_pkg::CFG_CW_STEP, 16'hFFFF);
          write_reg(edw_pkg::CFG_CCW_STEP, 16'h0001);
          write_reg(edw_pkg::CFG_DETENTS, 16'd20);
        end
        1: begin
          write_reg(edw_pkg::CFG_CW_STEP, 16'h7FFF);
          write_reg(edw_pkg::CFG_CCW_STEP, 16'h8000);
          write_reg(edw_pkg::CFG_DETENTS, 16'd0);
        end
        2: begin
          write_reg(edw_pkg::CFG_CW_STEP, 16'h8000);
          write_reg(edw_pkg::CFG_CCW_STEP, 16'h7FFF);
          write_reg(edw_pkg::CFG_DETENTS, 16'd360);
        end
        3: begin
          write_reg(edw_pkg::CFG_CW_STEP, 16'd3);
          write_reg(edw_pkg::CFG_CCW_STEP, 16'hFFF9);
          write_reg(edw_pkg::CFG_DETENTS, 16'd511);
        end
        4: begin
          write_reg(edw_pkg::CFG_CW_STEP, edw_pkg::CFG_DATA_W'($urandom()));
          write_reg(edw_pkg::CFG_CCW_STEP, edw_pkg::CFG_DATA_W'($urandom()));
          write_reg(edw_pkg::CFG_DETENTS, 16'hFE01);
        end
        default: begin
          write_reg(edw_pkg::CFG_CW_STEP, edw_pkg::CFG_DATA_W'($urandom()));
          write_reg(edw_pkg::CFG_CCW_STEP, edw_pkg::CFG_DATA_W'($urandom()));
          write_reg(edw_pkg::CFG_DETENTS, edw_pkg::CFG_DATA_W'($urandom_range(1, 360)));
          write_reg(CFG_UNUSED, edw_pkg::CFG_DATA_W'($urandom()));
        end
      endcase
      cfg_if.valid <= 1'b0;
      if (phase < 2) begin
        src_idle_pct = 25;
        snk_idle_pct = 87;
      end else if (phase < 4) begin
        src_idle_pct = 87;
        snk_idle_pct = 25;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // hold the output back while items keep coming
      if (phase == 5) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.awaited_reports.size() == 0)
      $display("encoder_detent_to_wheel_core: match");
    else
      $display("encoder_detent_to_wheel_core: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
rtl/edw_pkg.sv
rtl/edw_if.sv
rtl/edw_ram.sv
rtl/edw_div.sv
rtl/encoder_detent_to_wheel_core.sv
tb/tb.sv
